@@ design/pwc_pkg.sv @@
// shared types, constants and helpers of the page-table-entry write coalescer
package pwc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int COPY_CAP    = 1023;
  localparam int PAGE_BITS   = 12;

  localparam int ADDR_W  = 32;
  localparam int ENTRY_W = 64;
  localparam int LIMIT_W = 5;
  localparam int OFF_W   = 32;
  localparam int SHIFT_W = 6;
  localparam int COPY_W  = 10;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int MODE_W  = 3;
  localparam int IDX_W   = 2;

  localparam int BANKS       = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 120;

  // reset values of the frame mask and of the entry limit
  localparam logic [ENTRY_W-1:0] FRAME_MASK_RST = 64'h0000_3FFF_FFFF_F000;
  localparam logic [LIMIT_W-1:0] LIMIT_RST      = LIMIT_W'(MAX_ENTRIES);

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_WINDOW_BASE = 2'd0,
    REG_ENTRY_LIMIT = 2'd1,
    REG_FRAME_MASK  = 2'd2,
    REG_FLAG_MASK   = 2'd3
  } reg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE      = 3'd0,
    MODE_DUP_FIRST = 3'd1,
    MODE_REP_FIRST = 3'd2,
    MODE_DUP_LAST  = 3'd3,
    MODE_REP_LAST  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ACT_IDLE,
    ACT_START,
    ACT_COPY,
    ACT_APPEND,
    ACT_RESTART,
    ACT_DRAIN
  } act_e;

  // write of one literal entry into the entry store
  typedef struct packed {
    logic                   en;
    logic                   bank;
    logic [SLOT_W-1:0]      slot;
    logic [ENTRY_W-1:0]     data;
  } st_wr_t;

  // one closed request waiting to be drained
  typedef struct packed {
    logic                   bank;
    logic [OFF_W-1:0]       start_page;
    mode_e                  mode;
    logic [COPY_W-1:0]      copies;
    logic [CNT_W-1:0]       count;
  } job_t;

  // bank handed back once its last entry has been read
  typedef struct packed {
    logic                   en;
    logic                   bank;
  } rel_t;

  function automatic logic [SHIFT_W-1:0] lowest_set(input logic [ENTRY_W-1:0] m);
    logic [SHIFT_W-1:0] r;
    r = '0;
    for (int i = ENTRY_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = SHIFT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ design/pwc_front.sv @@
// front end: config registers, request state and per-write coalescing decision
module pwc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [pwc_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [pwc_pkg::ENTRY_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_action_i,
  input  logic [pwc_pkg::ADDR_W-1:0]    in_addr_i,
  input  logic [pwc_pkg::ENTRY_W-1:0]   in_entry_i,
  output pwc_pkg::st_wr_t               st_wr_o,
  output logic                          job_push_o,
  output pwc_pkg::job_t                 job_o,
  input  pwc_pkg::rel_t                 rel_i
);
  import pwc_pkg::*;

  localparam logic [COPY_W-1:0] COPY_MAX = COPY_W'(COPY_CAP);

  logic [ADDR_W-1:0]  window_base_q;
  logic [LIMIT_W-1:0] entry_limit_q;
  logic [ENTRY_W-1:0] frame_mask_q;
  logic [SHIFT_W-1:0] frame_sh_q;
  logic [ENTRY_W-1:0] flag_mask_q;

  logic               bank_q;
  logic [BANKS-1:0]   busy_q, busy_d;
  logic [CNT_W-1:0]   ec_q;
  logic [OFF_W-1:0]   start_q;
  logic [COPY_W-1:0]  cc_q;
  mode_e              mode_q;
  logic [OFF_W-1:0]   next_off_q;
  logic [ENTRY_W-1:0] last_q;

  logic [OFF_W-1:0]   off;
  logic [ENTRY_W-1:0] nf;
  logic [ENTRY_W-1:0] pf;
  logic [CNT_W-1:0]   lim;
  logic               contig, dup, rep, full, first;
  act_e               act;
  mode_e              new_mode;
  logic               accept;
  logic               new_bank_needed;

  assign off = OFF_W'(in_addr_i[ADDR_W-1:PAGE_BITS]) -
               OFF_W'(window_base_q[ADDR_W-1:PAGE_BITS]);
  assign nf  = (in_entry_i & frame_mask_q) >> frame_sh_q;
  assign pf  = (last_q & frame_mask_q) >> frame_sh_q;

  always_comb begin
    if (entry_limit_q == '0) begin
      lim = CNT_W'(1);
    end else if (CNT_W'(entry_limit_q) > CNT_W'(MAX_ENTRIES)) begin
      lim = CNT_W'(MAX_ENTRIES);
    end else begin
      lim = CNT_W'(entry_limit_q);
    end
  end

  assign contig = (off == next_off_q) && (cc_q != COPY_MAX);
  assign dup    = (in_entry_i == last_q);
  assign rep    = (((in_entry_i ^ last_q) & flag_mask_q) == '0) &&
                  ((nf - (ENTRY_W'(cc_q) + ENTRY_W'(1))) == pf);
  assign full   = (ec_q >= lim);
  assign first  = (ec_q == CNT_W'(1));

  always_comb begin
    act      = ACT_IDLE;
    new_mode = mode_q;
    if (in_action_i == ACTION_FLUSH) begin
      act = (ec_q == '0) ? ACT_IDLE : ACT_DRAIN;
    end else if (ec_q == '0) begin
      act = ACT_START;
    end else if (!contig) begin
      act = ACT_RESTART;
    end else if (cc_q == '0) begin
      if (dup) begin
        act      = ACT_COPY;
        new_mode = first ? MODE_DUP_FIRST : MODE_DUP_LAST;
      end else if (rep) begin
        act      = ACT_COPY;
        new_mode = first ? MODE_REP_FIRST : MODE_REP_LAST;
      end else if (full) begin
        act = ACT_RESTART;
      end else begin
        act = ACT_APPEND;
      end
    end else if (first && mode_q == MODE_DUP_FIRST && dup) begin
      act = ACT_COPY;
    end else if (first && mode_q == MODE_REP_FIRST && rep) begin
      act = ACT_COPY;
    end else if (mode_q == MODE_DUP_LAST && dup) begin
      act = ACT_COPY;
    end else if (mode_q == MODE_REP_LAST && rep) begin
      act = ACT_COPY;
    end else if ((mode_q == MODE_DUP_FIRST || mode_q == MODE_REP_FIRST) && !full) begin
      act = ACT_APPEND;
    end else begin
      act = ACT_RESTART;
    end
  end

  // closing a request hands the bank to the drain side and moves to the other one
  assign new_bank_needed = (act == ACT_RESTART) || (act == ACT_DRAIN);
  assign in_ready_o      = !(new_bank_needed && busy_q[!bank_q]);
  assign accept          = in_valid_i && in_ready_o;

  assign job_push_o      = accept && new_bank_needed;
  assign job_o.bank       = bank_q;
  assign job_o.start_page = start_q;
  assign job_o.mode       = mode_q;
  assign job_o.copies     = cc_q;
  assign job_o.count      = ec_q;

  always_comb begin
    st_wr_o.en   = 1'b0;
    st_wr_o.bank = bank_q;
    st_wr_o.slot = '0;
    st_wr_o.data = in_entry_i;
    case (act)
      ACT_START: begin
        st_wr_o.en = accept;
      end
      ACT_RESTART: begin
        st_wr_o.en   = accept;
        st_wr_o.bank = !bank_q;
      end
      ACT_APPEND: begin
        st_wr_o.en   = accept;
        st_wr_o.slot = ec_q[SLOT_W-1:0];
      end
      default: begin
        st_wr_o.en = 1'b0;
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    if (rel_i.en) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (job_push_o) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_base_q <= '0;
      entry_limit_q <= LIMIT_RST;
      frame_mask_q  <= FRAME_MASK_RST;
      frame_sh_q    <= lowest_set(FRAME_MASK_RST);
      flag_mask_q   <= '0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_WINDOW_BASE: window_base_q <= cfg_data_i[ADDR_W-1:0];
        REG_ENTRY_LIMIT: entry_limit_q <= cfg_data_i[LIMIT_W-1:0];
        REG_FRAME_MASK: begin
          frame_mask_q <= cfg_data_i;
          frame_sh_q   <= lowest_set(cfg_data_i);
        end
        REG_FLAG_MASK:   flag_mask_q <= cfg_data_i;
        default:         flag_mask_q <= flag_mask_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
      busy_q <= '0;
      ec_q   <= '0;
      cc_q   <= '0;
      mode_q <= MODE_NONE;
      start_q <= '0;
    end else begin
      busy_q <= busy_d;
      if (accept) begin
        case (act)
          ACT_START, ACT_RESTART: begin
            if (act == ACT_RESTART) begin
              bank_q <= !bank_q;
            end
            ec_q    <= CNT_W'(1);
            cc_q    <= '0;
            mode_q  <= MODE_NONE;
            start_q <= off;
          end
          ACT_COPY: begin
            cc_q   <= cc_q + COPY_W'(1);
            mode_q <= new_mode;
          end
          ACT_APPEND: begin
            ec_q <= ec_q + CNT_W'(1);
          end
          ACT_DRAIN: begin
            bank_q <= !bank_q;
            ec_q   <= '0;
          end
          default: begin
            ec_q <= ec_q;
          end
        endcase
      end
    end
  end

  // expected next page and the last literal entry of the open request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      case (act)
        ACT_START, ACT_RESTART: begin
          next_off_q <= off + OFF_W'(1);
          last_q     <= in_entry_i;
        end
        ACT_APPEND: begin
          next_off_q <= next_off_q + OFF_W'(1);
          last_q     <= in_entry_i;
        end
        ACT_COPY: begin
          next_off_q <= next_off_q + OFF_W'(1);
        end
        default: begin
          next_off_q <= next_off_q;
        end
      endcase
    end
  end

endmodule

@@ design/pwc_job_queue.sv @@
// small queue of closed requests between the front end and the drain side
module pwc_job_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pwc_pkg::job_t  job_i,
  input  logic           pop_i,
  output logic           head_valid_o,
  output pwc_pkg::job_t  head_o
);
  import pwc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t                 slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]       cnt_q, cnt_d;

  assign head_valid_o = (cnt_q != '0);
  assign head_o       = slots_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (PTR_W + 1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ design/pwc_back.sv @@
// drain side: two-bank entry store and output register, one entry per cycle while the output is ready
module pwc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pwc_pkg::st_wr_t               st_wr_i,
  input  logic                          head_valid_i,
  input  pwc_pkg::job_t                 head_i,
  output logic                          pop_o,
  output pwc_pkg::rel_t                 rel_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pwc_pkg::OFF_W-1:0]     out_start_o,
  output pwc_pkg::mode_e                out_mode_o,
  output logic [pwc_pkg::COPY_W-1:0]    out_copies_o,
  output logic [pwc_pkg::SLOT_W-1:0]    out_slot_o,
  output logic [pwc_pkg::ENTRY_W-1:0]   out_entry_o,
  output logic                          out_last_o
);
  import pwc_pkg::*;

  logic [ENTRY_W-1:0] store_q [BANKS][MAX_ENTRIES];
  logic [SLOT_W-1:0]  idx_q;
  logic               out_valid_q;
  logic               load, is_last;

  logic [OFF_W-1:0]   start_q;
  mode_e              mode_q;
  logic [COPY_W-1:0]  copies_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [ENTRY_W-1:0] entry_q;
  logic               last_q;

  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign is_last = (CNT_W'(idx_q) + CNT_W'(1)) == head_i.count;
  assign pop_o   = load && is_last;
  // the bank is free as soon as its last entry sits in the output register
  assign rel_o.en   = pop_o;
  assign rel_o.bank = head_i.bank;

  always_ff @(posedge clk_i) begin
    if (st_wr_i.en) begin
      store_q[st_wr_i.bank][st_wr_i.slot] <= st_wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? '0 : idx_q + SLOT_W'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      start_q  <= head_i.start_page;
      mode_q   <= head_i.mode;
      copies_q <= head_i.copies;
      slot_q   <= idx_q;
      entry_q  <= store_q[head_i.bank][idx_q];
      last_q   <= is_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_start_o  = start_q;
  assign out_mode_o   = mode_q;
  assign out_copies_o = copies_q;
  assign out_slot_o   = slot_q;
  assign out_entry_o  = entry_q;
  assign out_last_o   = last_q;

endmodule

@@ design/pte_write_coalescer.sv @@
// top level of the page-table-entry write coalescer
//
// Writes are taken one per cycle while the front end is ready and merged on
// the fly into the open request (literal entry, duplicate or replicated copy,
// or close-and-restart). When a request closes, by a flush or by a write that
// cannot join it, its header goes into a two-deep request queue and its entries
// stay in one of two store banks while the next request fills the other bank.
// The drain side emits one result per literal entry, one per cycle while the
// output is ready, through an output register. A write or a flush that has to
// close a request stalls only while the other bank still holds a request that
// has not been fully drained. The registers are written through the config
// port, which is always ready; a write takes effect from the next item on.
module pte_write_coalescer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pwc_pkg::IDX_W-1:0]        cfg_index_i,
  input  logic [pwc_pkg::ENTRY_W-1:0]      cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // address [31:0], entry [95:32]
  input  logic [pwc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // action [0]
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // start_page [31:0], mode [34:32], copies [44:35], slot [48:45],
  // entry_out [112:49], zero [119:113]
  output logic [pwc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast
);
  import pwc_pkg::*;

  st_wr_t             st_wr;
  logic               job_push;
  job_t               job;
  logic               head_valid;
  job_t               head;
  logic               pop;
  rel_t               rel;
  logic [OFF_W-1:0]   out_start;
  mode_e              out_mode;
  logic [COPY_W-1:0]  out_copies;
  logic [SLOT_W-1:0]  out_slot;
  logic [ENTRY_W-1:0] out_entry;

  assign cfg_ready_o = 1'b1;

  pwc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_addr_i   (s_axis_tdata[ADDR_W-1:0]),
    .in_entry_i  (s_axis_tdata[ADDR_W+ENTRY_W-1:ADDR_W]),
    .st_wr_o     (st_wr),
    .job_push_o  (job_push),
    .job_o       (job),
    .rel_i       (rel)
  );

  pwc_job_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (job_push),
    .job_i        (job),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  pwc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .st_wr_i      (st_wr),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .rel_o        (rel),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_start_o  (out_start),
    .out_mode_o   (out_mode),
    .out_copies_o (out_copies),
    .out_slot_o   (out_slot),
    .out_entry_o  (out_entry),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {
    (OUT_DATA_W - OFF_W - MODE_W - COPY_W - SLOT_W - ENTRY_W)'(0),
    out_entry, out_slot, out_copies, out_mode, out_start
  };

endmodule
